// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the key/value table.
// Needs signals named clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PKV_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define PKV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pkv_pkg.sv
// Shared types and constants of the pooled key/value table.
// No dependencies; imported by the interface, controller, datapath, top and checker files.
package pkv_pkg;

	// Field widths of the request and response channels
	localparam int FUNC_W   = 3;
	localparam int HANDLE_W = 6;
	localparam int KEY_W    = 32;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 7;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_CREATE   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_GET      = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_SET      = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_DELETE   = 3'd4;

	// Response status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic                init_wr;    // clearing pass: write one entry
		logic                latch;      // capture request fields
		logic                hdr_rd;     // read header entry at handle
		logic                hdr_chk;    // capture item count of the header
		logic                scan_start; // reset scan pointer and hit flag
		logic                scan_step;  // one scan read/compare
		logic                act;        // apply lookup outcome
		logic                alloc;      // take popped free entry
		logic                res_set;    // fixed result, all fields but status zero
		logic [STATUS_W-1:0] res_status; // status for res_set
		logic                load_out;   // move result into output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic init_last;  // clearing pass at last entry
		logic op_create;
		logic op_unused;  // func code outside the defined set
		logic free_empty;
		logic handle_oob; // handle beyond the pool
		logic live;       // header entry is a live dictionary
		logic scan_hit;
		logic scan_miss;
		logic need_alloc; // set of a new key with a free entry left
	} sts_t;

endpackage

// File: rtl/pkv_channel_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on pkv_pkg for the field widths.
interface pkv_req_if;
	import pkv_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [FUNC_W-1:0]          func;
	logic [HANDLE_W-1:0]        dict_handle;
	logic signed [KEY_W-1:0]    key;
	logic [VALUE_W-1:0]         value;

	modport source (output valid, func, dict_handle, key, value, input ready);
	modport sink   (input valid, func, dict_handle, key, value, output ready);
endinterface

interface pkv_rsp_if;
	import pkv_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [VALUE_W-1:0]  read_value;
	logic [HANDLE_W-1:0] new_handle;
	logic [TOTAL_W-1:0]  entry_total;

	modport source (output valid, status, found, read_value, new_handle, entry_total,
		input ready);
	modport sink   (input valid, status, found, read_value, new_handle, entry_total,
		output ready);
endinterface

// File: rtl/pkv_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/pkv_ctrl.sv
// Controller state machine of the key/value table: sequences clearing,
// lookup scan, update and result transfer. Depends on pkv_pkg.
module pkv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	output pkv_pkg::cmd_t cmd,
	input  pkv_pkg::sts_t sts
);
	import pkv_pkg::*;

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DECODE = 4'd2;
	localparam logic [3:0] S_HDR    = 4'd3;
	localparam logic [3:0] S_HCHK   = 4'd4;
	localparam logic [3:0] S_SCAN   = 4'd5;
	localparam logic [3:0] S_ACT    = 4'd6;
	localparam logic [3:0] S_POP    = 4'd7;
	localparam logic [3:0] S_ALLOC  = 4'd8;
	localparam logic [3:0] S_EMIT   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// Output register can take a result when empty or being drained
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.op_unused) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_OK;
					state_d        = S_EMIT;
				end else if (sts.op_create) begin
					if (sts.free_empty) begin
						cmd.res_set    = 1'b1;
						cmd.res_status = ST_POOL_FULL;
						state_d        = S_EMIT;
					end else begin
						state_d = S_POP;
					end
				end else if (sts.handle_oob) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					state_d        = S_EMIT;
				end else begin
					state_d = S_HDR;
				end
			end
			S_HDR: begin
				cmd.hdr_rd = 1'b1;
				state_d    = S_HCHK;
			end
			S_HCHK: begin
				cmd.hdr_chk = 1'b1;
				if (sts.live) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					state_d        = S_EMIT;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit || sts.scan_miss) begin
					state_d = S_ACT;
				end
			end
			S_ACT: begin
				cmd.act = 1'b1;
				state_d = sts.need_alloc ? S_POP : S_EMIT;
			end
			S_POP: begin
				// free list head read lands in the next cycle
				state_d = S_ALLOC;
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
endmodule

// File: rtl/pkv_dp.sv
// Datapath of the key/value table: entry, item count and free list RAMs,
// scan pipeline, free list pointers and result registers. Depends on pkv_pkg, pkv_ram.
module pkv_dp #(
	parameter int POOL_ENTRIES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pkv_pkg::cmd_t                   cmd,
	output pkv_pkg::sts_t                   sts,
	input  logic [pkv_pkg::FUNC_W-1:0]      in_func,
	input  logic [pkv_pkg::HANDLE_W-1:0]    in_dict_handle,
	input  logic signed [pkv_pkg::KEY_W-1:0] in_key,
	input  logic [pkv_pkg::VALUE_W-1:0]     in_value,
	output logic [pkv_pkg::STATUS_W-1:0]    out_status,
	output logic                            out_found,
	output logic [pkv_pkg::VALUE_W-1:0]     out_read_value,
	output logic [pkv_pkg::HANDLE_W-1:0]    out_new_handle,
	output logic [pkv_pkg::TOTAL_W-1:0]     out_entry_total
);
	import pkv_pkg::*;

	localparam int IW = $clog2(POOL_ENTRIES);
	localparam int CW = $clog2(POOL_ENTRIES + 1);
	localparam int EW = 2 + IW + KEY_W + VALUE_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(POOL_ENTRIES - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(POOL_ENTRIES);

	// Request registers
	logic [FUNC_W-1:0]   func_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [KEY_W-1:0]    key_q;
	logic [VALUE_W-1:0]  value_q;

	// Free list and scan control
	logic [IW-1:0] init_q;
	logic [IW-1:0] free_head_q;
	logic [IW-1:0] free_tail_q;
	logic [CW-1:0] free_count_q;
	logic [IW-1:0] scan_q;
	logic          scan_busy_q;
	logic          valid_s1;
	logic [IW-1:0] idx_s1;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [VALUE_W-1:0] hit_value_q;
	logic [CW-1:0] cnt_q;

	// Pending result and output register
	logic [STATUS_W-1:0] res_status_q;
	logic                res_found_q;
	logic [VALUE_W-1:0]  res_rval_q;
	logic [HANDLE_W-1:0] res_nh_q;
	logic [TOTAL_W-1:0]  res_total_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_found_q;
	logic [VALUE_W-1:0]  out_rval_q;
	logic [HANDLE_W-1:0] out_nh_q;
	logic [TOTAL_W-1:0]  out_total_q;

	// RAM ports
	logic          ent_we;
	logic [IW-1:0] ent_waddr;
	logic [EW-1:0] ent_wdata;
	logic [IW-1:0] ent_raddr;
	logic [EW-1:0] ent_rd;
	logic          cnt_we;
	logic [IW-1:0] cnt_waddr;
	logic [CW-1:0] cnt_wdata;
	logic [CW-1:0] cnt_rd;
	logic          fifo_we;
	logic [IW-1:0] fifo_waddr;
	logic [IW-1:0] fifo_wdata;
	logic [IW-1:0] fifo_rd;

	// Decoded fields
	logic [IW-1:0]      handle_idx;
	logic               ent_in_use;
	logic               ent_hdr;
	logic [IW-1:0]      ent_owner;
	logic [KEY_W-1:0]   ent_key;
	logic [VALUE_W-1:0] ent_value;
	logic               match;
	logic               is_create;
	logic               is_contains;
	logic               is_get;
	logic               is_set;
	logic               is_del;
	logic               free_empty;
	logic [IW-1:0]      next_head;
	logic [IW-1:0]      next_tail;
	logic [CW-1:0]      cnt_inc;
	logic [CW-1:0]      cnt_dec;

	assign handle_idx = IW'(handle_q);
	assign ent_in_use = ent_rd[EW-1];
	assign ent_hdr    = ent_rd[EW-2];
	assign ent_owner  = ent_rd[EW-3 -: IW];
	assign ent_key    = ent_rd[VALUE_W +: KEY_W];
	assign ent_value  = ent_rd[VALUE_W-1:0];

	assign is_create   = (func_q == FUNC_CREATE);
	assign is_contains = (func_q == FUNC_CONTAINS);
	assign is_get      = (func_q == FUNC_GET);
	assign is_set      = (func_q == FUNC_SET);
	assign is_del      = (func_q == FUNC_DELETE);
	assign free_empty  = (free_count_q == '0);

	// Circular pointer steps and saturating count updates
	assign next_head = (free_head_q == LAST_IDX) ? '0 : free_head_q + 1'b1;
	assign next_tail = (free_tail_q == LAST_IDX) ? '0 : free_tail_q + 1'b1;
	assign cnt_inc   = (cnt_q < FULL_CNT) ? cnt_q + 1'b1 : cnt_q;
	assign cnt_dec   = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;

	// Scan compare on the registered entry RAM read
	assign match = valid_s1 && ent_in_use && !ent_hdr &&
		(ent_owner == handle_idx) && (ent_key == key_q);

	// Status to the controller
	always_comb begin
		sts            = '0;
		sts.init_last  = (init_q == LAST_IDX);
		sts.op_create  = is_create;
		sts.op_unused  = (func_q > FUNC_DELETE);
		sts.free_empty = free_empty;
		sts.handle_oob = (int'(handle_q) >= POOL_ENTRIES);
		sts.live       = ent_in_use && ent_hdr;
		sts.scan_hit   = match;
		sts.scan_miss  = valid_s1 && !match && (idx_s1 == LAST_IDX);
		sts.need_alloc = is_set && !hit_q && !free_empty;
	end

	// Entry RAM write selection
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = hit_idx_q;
		ent_wdata = {1'b1, 1'b0, handle_idx, key_q, value_q};
		if (cmd.init_wr) begin
			ent_we    = 1'b1;
			ent_waddr = init_q;
			ent_wdata = '0;
		end else if (cmd.alloc) begin
			ent_we    = 1'b1;
			ent_waddr = fifo_rd;
			if (is_create) begin
				ent_wdata = {1'b1, 1'b1, fifo_rd, {KEY_W{1'b0}}, {VALUE_W{1'b0}}};
			end
		end else if (cmd.act && hit_q && is_set) begin
			ent_we = 1'b1;
		end else if (cmd.act && hit_q && is_del) begin
			ent_we    = 1'b1;
			ent_wdata = {1'b0, 1'b0, handle_idx, key_q, value_q};
		end
	end

	// Item count RAM write selection
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = handle_idx;
		cnt_wdata = cnt_inc;
		if (cmd.alloc) begin
			cnt_we = 1'b1;
			if (is_create) begin
				cnt_waddr = fifo_rd;
				cnt_wdata = '0;
			end
		end else if (cmd.act && hit_q && is_del) begin
			cnt_we    = 1'b1;
			cnt_wdata = cnt_dec;
		end
	end

	// Free list RAM write selection
	always_comb begin
		fifo_we    = 1'b0;
		fifo_waddr = free_tail_q;
		fifo_wdata = hit_idx_q;
		if (cmd.init_wr) begin
			fifo_we    = 1'b1;
			fifo_waddr = init_q;
			fifo_wdata = init_q;
		end else if (cmd.act && hit_q && is_del) begin
			fifo_we = 1'b1;
		end
	end

	assign ent_raddr = cmd.hdr_rd ? handle_idx : scan_q;

	pkv_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rd)
	);

	pkv_ram #(.WIDTH(CW), .DEPTH(POOL_ENTRIES)) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (handle_idx),
		.rdata (cnt_rd)
	);

	pkv_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_free_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (fifo_waddr),
		.wdata (fifo_wdata),
		.raddr (free_head_q),
		.rdata (fifo_rd)
	);

	// Clearing pass, free list pointers and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q       <= '0;
			free_head_q  <= '0;
			free_tail_q  <= '0;
			free_count_q <= FULL_CNT;
			scan_q       <= '0;
			scan_busy_q  <= 1'b0;
			valid_s1     <= 1'b0;
			hit_q        <= 1'b0;
		end else begin
			if (cmd.init_wr) begin
				init_q <= init_q + 1'b1;
			end
			if (cmd.alloc) begin
				free_head_q  <= next_head;
				free_count_q <= free_count_q - 1'b1;
			end else if (cmd.act && hit_q && is_del) begin
				free_tail_q  <= next_tail;
				free_count_q <= free_count_q + 1'b1;
			end
			if (cmd.scan_start) begin
				scan_q      <= '0;
				scan_busy_q <= 1'b1;
				valid_s1    <= 1'b0;
				hit_q       <= 1'b0;
			end else if (cmd.scan_step) begin
				valid_s1 <= scan_busy_q;
				if (scan_busy_q) begin
					scan_q <= scan_q + 1'b1;
				end
				if (scan_q == LAST_IDX) begin
					scan_busy_q <= 1'b0;
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// Request capture, scan payload and item count
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q   <= in_func;
			handle_q <= in_dict_handle;
			key_q    <= in_key;
			value_q  <= in_value;
		end
		if (cmd.hdr_chk) begin
			cnt_q <= cnt_rd;
		end
		if (cmd.scan_step) begin
			idx_s1 <= scan_q;
			if (match) begin
				hit_idx_q   <= idx_s1;
				hit_value_q <= ent_value;
			end
		end
	end

	// Result assembly
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			res_found_q  <= 1'b0;
			res_rval_q   <= '0;
			res_nh_q     <= '0;
			res_total_q  <= '0;
		end else if (cmd.act) begin
			if ((is_get || is_del) && !hit_q) begin
				res_status_q <= ST_NOT_FOUND;
			end else if (is_set && !hit_q && free_empty) begin
				res_status_q <= ST_POOL_FULL;
			end else begin
				res_status_q <= ST_OK;
			end
			res_found_q <= hit_q && (is_contains || is_get || is_del);
			res_rval_q  <= (is_get && hit_q) ? hit_value_q : '0;
			res_nh_q    <= '0;
			res_total_q <= TOTAL_W'((is_del && hit_q) ? cnt_dec : cnt_q);
		end else if (cmd.alloc) begin
			res_status_q <= ST_OK;
			res_found_q  <= 1'b0;
			res_rval_q   <= '0;
			res_nh_q     <= is_create ? HANDLE_W'(fifo_rd) : '0;
			res_total_q  <= is_create ? '0 : TOTAL_W'(cnt_inc);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_rval_q   <= res_rval_q;
			out_nh_q     <= res_nh_q;
			out_total_q  <= res_total_q;
		end
	end

	assign out_status      = out_status_q;
	assign out_found       = out_found_q;
	assign out_read_value  = out_rval_q;
	assign out_new_handle  = out_nh_q;
	assign out_entry_total = out_total_q;
endmodule

// File: rtl/pooled_key_value_table.sv
// Pooled key/value table: several dictionaries of 32-bit keys and values
// sharing one pool of POOL_ENTRIES entries handed out from a FIFO free list.
// Each request is one of create, contains, get, set or delete (any other code
// gets an ok response with zero fields) and gives exactly one response. Requests
// are handled one at a time. Create takes an entry from the free list; the other
// operations search the entry RAM one entry per cycle, stopping at the matching
// key, and a set that appends a new key then takes an entry from the free list.
// The single read port of the entry RAM sets that search rate. After reset a
// clearing pass over all POOL_ENTRIES entries initializes the entry flags and
// the free list; req.ready stays low until it ends. A finished response waits in
// an output register while the next request is accepted.
module pooled_key_value_table #(
	parameter int POOL_ENTRIES = 64
) (
	input logic      clk,
	input logic      arst_n,
	pkv_req_if.sink  req,
	pkv_rsp_if.source rsp
);
	import pkv_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	pkv_dp #(.POOL_ENTRIES(POOL_ENTRIES)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_func         (req.func),
		.in_dict_handle  (req.dict_handle),
		.in_key          (req.key),
		.in_value        (req.value),
		.out_status      (rsp.status),
		.out_found       (rsp.found),
		.out_read_value  (rsp.read_value),
		.out_new_handle  (rsp.new_handle),
		.out_entry_total (rsp.entry_total)
	);
endmodule

// File: rtl/pkv_checker.sv
// Port-level checker for the pooled key/value table, bound to the top level.
// Depends on pkv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pkv_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [pkv_pkg::STATUS_W-1:0]   rsp_status,
	input logic                           rsp_found,
	input logic [pkv_pkg::VALUE_W-1:0]    rsp_read_value,
	input logic [pkv_pkg::HANDLE_W-1:0]   rsp_new_handle,
	input logic [pkv_pkg::TOTAL_W-1:0]    rsp_entry_total
);
	import pkv_pkg::*;

	// Response stays offered until its transfer
	`PKV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

	// Stalled response payload does not change
	`PKV_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_found) && $stable(rsp_read_value) && $stable(rsp_new_handle) && $stable(rsp_entry_total), "response payload changed while stalled")

	// One request at a time: ready drops right after a transfer
	`PKV_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")

	// Found flag, returned value or new handle only come with an ok status
	`PKV_ASSERT_SAME(a_ok_payload, rsp_valid && (rsp_found || rsp_read_value != '0 || rsp_new_handle != '0), rsp_status == ST_OK, "payload with error status")
endmodule

bind pooled_key_value_table pkv_checker u_pkv_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_found       (rsp.found),
	.rsp_read_value  (rsp.read_value),
	.rsp_new_handle  (rsp.new_handle),
	.rsp_entry_total (rsp.entry_total)
);
